// ===== rtl/core/iir_pkg.sv =====
// Shared constants, codes and types of the integer image rescaler.
package iir_pkg;

  localparam int SRC_DIM_MAX = 64;
  localparam int DST_DIM_MAX = 1024;

  localparam int PIX_W      = 8;
  localparam int SRC_W      = 7;
  localparam int DST_W      = 11;
  localparam int POS_W      = $clog2(SRC_DIM_MAX);
  localparam int ADDR_W     = 2 * POS_W;
  localparam int STORE_DEPTH = SRC_DIM_MAX * SRC_DIM_MAX;
  localparam int OUT_POS_W  = $clog2(DST_DIM_MAX);
  localparam int CFG_DATA_W = DST_W;
  localparam int CFG_IDX_W  = 3;
  localparam int DIV_STEPS  = DST_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd3;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_SIZE  = 2'd1,
    STATUS_BAD_IMAGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    GEO_IDLE,
    GEO_MUL,
    GEO_DIV,
    GEO_FIN
  } geo_state_t;

endpackage

// ===== rtl/core/iir_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module iir_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/integer_image_rescaler_unit.sv =====
// Top level of the integer image rescaler: pixel store, load and pull streams.
//
// Usage: configure src/dst height and width through the cfg write port, then
// send transactions on the input channel. A transaction with in_kind 0 loads
// the next source pixel in raster order and returns nothing. A transaction
// with in_kind 1 pulls the next target pixel, returned on the output channel
// with status, row end and last flags. A bad size or a non-uniform shrink
// block answers every pull with an error status and last set.
// A pull result is registered in the pixel store read stage, then in the
// output register. Loads are taken one per cycle while in_stall is low; a
// pull in the read stage holds in_stall high, so no transaction is taken
// until that pull moves on to the output register.
// A write to one of the four size registers starts the geometry unit (range
// and product check, then an 11-step restoring divider for the scale
// factor): in_stall stays high until it is done. Such a write restarts
// both streams. Reset sets all four size registers to 1 and both streams
// to the first pixel; the pixel store is not cleared. While out_stall
// holds a result, in_stall is high and no transaction is taken.
module integer_image_rescaler_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [iir_pkg::PIX_W-1:0]         in_pixel_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [iir_pkg::PIX_W-1:0]         out_pixel_out,
  output logic [1:0]                        out_status,
  output logic                              out_row_end,
  output logic                              out_last,
  input  logic                              cfg_we,
  input  logic [iir_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iir_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int SW = iir_pkg::SRC_W;
  localparam int DW = iir_pkg::DST_W;
  localparam int PW = iir_pkg::POS_W;
  localparam int OW = iir_pkg::OUT_POS_W;
  localparam int AW = iir_pkg::ADDR_W;
  localparam int XW = iir_pkg::PIX_W;
  localparam int CW = iir_pkg::DIV_CNT_W;

  // configuration registers
  logic [SW-1:0] src_height_r, src_width_r;
  logic [DW-1:0] dst_height_r, dst_width_r;
  logic          cfg_hit;

  // geometry
  iir_pkg::geo_state_t geo_state_r, geo_state_nxt;
  logic          ok_r, shrink_r;
  logic [DW-1:0] k_r;
  logic          range_ok_r, prod_eq_r, shrink_calc_r;
  logic [DW:0]   div_rem_r;
  logic [DW-1:0] div_q_r, div_dvs_r;
  logic [CW-1:0] div_cnt_r;
  logic [DW:0]   div_rem_sh;
  logic          div_fit;
  logic          range_ok_c, prod_eq_c, shrink_c;
  logic [SW+DW-1:0] prod_a, prod_b;

  // load stream
  logic [SW-1:0] load_row_r, load_col_r, load_row_nxt, load_col_nxt;
  logic [OW-1:0] bro_r, bco_r, bro_nxt, bco_nxt;
  logic [SW:0]   load_col_inc, load_row_inc;
  logic [DW-1:0] bro_inc, bco_inc;
  logic [PW-1:0] anchor_row, anchor_col;
  logic          load_in_range, load_check, load_clear;

  // pull stream
  logic [OW-1:0] out_row_r, out_col_r, out_row_nxt, out_col_nxt;
  logic [PW-1:0] src_row_r, src_col_r, src_row_nxt, src_col_nxt;
  logic [OW-1:0] sub_row_r, sub_col_r, sub_row_nxt, sub_col_nxt;
  logic [DW-1:0] out_col_inc, out_row_inc, sub_col_inc, sub_row_inc;
  logic [PW:0]   src_col_step, src_row_step;
  logic          pull_row_end, pull_last, pull_err;
  iir_pkg::status_t pull_status;

  // accept and store access
  logic          acc, acc_load, acc_pull;
  logic          wr_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [XW-1:0] rd_data;

  // read stage
  logic          s1_valid_r, s1_pull_r, s1_check_r, s1_clear_r;
  logic          s1_row_end_r, s1_last_r;
  iir_pkg::status_t s1_status_r;
  logic [XW-1:0] s1_px_r;
  logic          mismatch_r, mismatch_now, mism_b;

  // output register
  logic          out_valid_r;
  logic [XW-1:0] out_pixel_r;
  iir_pkg::status_t out_status_r;
  logic          out_row_end_r, out_last_r;

  always_comb begin
    unique case (cfg_index)
      iir_pkg::CFG_SRC_HEIGHT,
      iir_pkg::CFG_SRC_WIDTH,
      iir_pkg::CFG_DST_HEIGHT,
      iir_pkg::CFG_DST_WIDTH: cfg_hit = cfg_we;
      default:                cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_height_r <= SW'(1);
      src_width_r  <= SW'(1);
      dst_height_r <= DW'(1);
      dst_width_r  <= DW'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        iir_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_data[SW-1:0];
        iir_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_data[SW-1:0];
        iir_pkg::CFG_DST_HEIGHT: dst_height_r <= cfg_data;
        iir_pkg::CFG_DST_WIDTH:  dst_width_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // geometry unit: range and aspect check, then scale factor by division
  assign prod_a = (SW+DW)'(src_height_r) * (SW+DW)'(dst_width_r);
  assign prod_b = (SW+DW)'(dst_height_r) * (SW+DW)'(src_width_r);
  assign prod_eq_c = (prod_a == prod_b);
  assign range_ok_c = (src_height_r != '0) && (src_height_r <= SW'(iir_pkg::SRC_DIM_MAX)) &&
                      (src_width_r != '0) && (src_width_r <= SW'(iir_pkg::SRC_DIM_MAX)) &&
                      (dst_height_r != '0) && (dst_height_r <= DW'(iir_pkg::DST_DIM_MAX)) &&
                      (dst_width_r != '0) && (dst_width_r <= DW'(iir_pkg::DST_DIM_MAX));
  assign shrink_c = (DW'(src_height_r) > dst_height_r);

  assign div_rem_sh = {div_rem_r[DW-1:0], div_q_r[DW-1]};
  assign div_fit    = (div_rem_sh >= {1'b0, div_dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      geo_state_r <= iir_pkg::GEO_IDLE;
    end else begin
      geo_state_r <= geo_state_nxt;
    end
  end

  always_comb begin
    geo_state_nxt = geo_state_r;
    if (cfg_hit) begin
      geo_state_nxt = iir_pkg::GEO_MUL;
    end else begin
      unique case (geo_state_r)
        iir_pkg::GEO_IDLE: geo_state_nxt = iir_pkg::GEO_IDLE;
        iir_pkg::GEO_MUL:  geo_state_nxt = iir_pkg::GEO_DIV;
        iir_pkg::GEO_DIV: begin
          if (div_cnt_r == CW'(iir_pkg::DIV_STEPS - 1)) begin
            geo_state_nxt = iir_pkg::GEO_FIN;
          end
        end
        iir_pkg::GEO_FIN:  geo_state_nxt = iir_pkg::GEO_IDLE;
        default:           geo_state_nxt = iir_pkg::GEO_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r     <= 1'b1;
      shrink_r <= 1'b0;
      k_r      <= DW'(1);
    end else if (geo_state_r == iir_pkg::GEO_FIN) begin
      ok_r     <= range_ok_r && prod_eq_r && (div_rem_r == '0);
      shrink_r <= range_ok_r && prod_eq_r && (div_rem_r == '0) && shrink_calc_r;
      k_r      <= (range_ok_r && prod_eq_r && (div_rem_r == '0)) ? div_q_r : DW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (geo_state_r == iir_pkg::GEO_MUL) begin
      range_ok_r    <= range_ok_c;
      prod_eq_r     <= prod_eq_c;
      shrink_calc_r <= shrink_c;
      div_rem_r     <= '0;
      div_cnt_r     <= '0;
      div_q_r       <= shrink_c ? DW'(src_height_r) : dst_height_r;
      div_dvs_r     <= shrink_c ? dst_height_r : DW'(src_height_r);
    end else if (geo_state_r == iir_pkg::GEO_DIV) begin
      div_rem_r <= div_fit ? (div_rem_sh - {1'b0, div_dvs_r}) : div_rem_sh;
      div_q_r   <= {div_q_r[DW-2:0], div_fit};
      div_cnt_r <= div_cnt_r + CW'(1);
    end
  end

  // handshake
  assign in_stall = cfg_we || (geo_state_r != iir_pkg::GEO_IDLE) ||
                    (s1_valid_r && s1_pull_r) || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;
  assign acc_load = acc && !in_kind;
  assign acc_pull = acc && in_kind;

  // load stream: store pixel, read block anchor, advance raster position
  assign load_in_range = (load_row_r < SW'(iir_pkg::SRC_DIM_MAX)) &&
                         (load_col_r < SW'(iir_pkg::SRC_DIM_MAX));
  assign anchor_row = load_row_r[PW-1:0] - bro_r[PW-1:0];
  assign anchor_col = load_col_r[PW-1:0] - bco_r[PW-1:0];
  assign load_check = ok_r && shrink_r && ((bro_r != '0) || (bco_r != '0));
  assign load_clear = (load_row_r == '0) && (load_col_r == '0);
  assign load_col_inc = {1'b0, load_col_r} + (SW+1)'(1);
  assign load_row_inc = {1'b0, load_row_r} + (SW+1)'(1);
  assign bco_inc = {1'b0, bco_r} + DW'(1);
  assign bro_inc = {1'b0, bro_r} + DW'(1);

  always_comb begin
    load_row_nxt = load_row_r;
    load_col_nxt = load_col_r;
    bro_nxt      = bro_r;
    bco_nxt      = bco_r;
    if (cfg_hit) begin
      load_row_nxt = '0;
      load_col_nxt = '0;
      bro_nxt      = '0;
      bco_nxt      = '0;
    end else if (acc_load) begin
      if (load_col_inc >= {1'b0, src_width_r}) begin
        load_col_nxt = '0;
        bco_nxt      = '0;
        if (load_row_inc >= {1'b0, src_height_r}) begin
          load_row_nxt = '0;
          bro_nxt      = '0;
        end else begin
          load_row_nxt = load_row_inc[SW-1:0];
          bro_nxt      = (bro_inc >= k_r) ? '0 : bro_inc[OW-1:0];
        end
      end else begin
        load_col_nxt = load_col_inc[SW-1:0];
        bco_nxt      = (bco_inc >= k_r) ? '0 : bco_inc[OW-1:0];
      end
    end
  end

  // pull stream: decide status from the latest mismatch, advance position
  assign mism_b = s1_valid_r && !s1_pull_r && s1_check_r && (rd_data != s1_px_r);
  assign mismatch_now = ((s1_valid_r && !s1_pull_r && s1_clear_r) ? 1'b0 : mismatch_r) |
                        mism_b;
  assign pull_err = !ok_r || (shrink_r && mismatch_now);

  always_comb begin
    if (!ok_r) begin
      pull_status = iir_pkg::STATUS_BAD_SIZE;
    end else if (pull_err) begin
      pull_status = iir_pkg::STATUS_BAD_IMAGE;
    end else begin
      pull_status = iir_pkg::STATUS_OK;
    end
  end

  assign out_col_inc  = {1'b0, out_col_r} + DW'(1);
  assign out_row_inc  = {1'b0, out_row_r} + DW'(1);
  assign pull_row_end = (out_col_inc >= dst_width_r);
  assign pull_last    = pull_row_end && (out_row_inc >= dst_height_r);
  assign sub_col_inc  = {1'b0, sub_col_r} + DW'(1);
  assign sub_row_inc  = {1'b0, sub_row_r} + DW'(1);
  assign src_col_step = {1'b0, src_col_r} + {1'b0, k_r[PW-1:0]};
  assign src_row_step = {1'b0, src_row_r} + {1'b0, k_r[PW-1:0]};

  always_comb begin
    out_row_nxt = out_row_r;
    out_col_nxt = out_col_r;
    src_row_nxt = src_row_r;
    src_col_nxt = src_col_r;
    sub_row_nxt = sub_row_r;
    sub_col_nxt = sub_col_r;
    if (cfg_hit) begin
      out_row_nxt = '0;
      out_col_nxt = '0;
      src_row_nxt = '0;
      src_col_nxt = '0;
      sub_row_nxt = '0;
      sub_col_nxt = '0;
    end else if (acc_pull && !pull_err) begin
      if (pull_row_end) begin
        out_col_nxt = '0;
        src_col_nxt = '0;
        sub_col_nxt = '0;
        if (pull_last) begin
          out_row_nxt = '0;
          src_row_nxt = '0;
          sub_row_nxt = '0;
        end else begin
          out_row_nxt = out_row_inc[OW-1:0];
          if (shrink_r) begin
            src_row_nxt = src_row_step[PW-1:0];
          end else if (sub_row_inc >= k_r) begin
            sub_row_nxt = '0;
            src_row_nxt = src_row_r + PW'(1);
          end else begin
            sub_row_nxt = sub_row_inc[OW-1:0];
          end
        end
      end else begin
        out_col_nxt = out_col_inc[OW-1:0];
        if (shrink_r) begin
          src_col_nxt = src_col_step[PW-1:0];
        end else if (sub_col_inc >= k_r) begin
          sub_col_nxt = '0;
          src_col_nxt = src_col_r + PW'(1);
        end else begin
          sub_col_nxt = sub_col_inc[OW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_row_r <= '0;
      load_col_r <= '0;
      bro_r      <= '0;
      bco_r      <= '0;
      out_row_r  <= '0;
      out_col_r  <= '0;
      src_row_r  <= '0;
      src_col_r  <= '0;
      sub_row_r  <= '0;
      sub_col_r  <= '0;
      mismatch_r <= 1'b0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      load_row_r <= load_row_nxt;
      load_col_r <= load_col_nxt;
      bro_r      <= bro_nxt;
      bco_r      <= bco_nxt;
      out_row_r  <= out_row_nxt;
      out_col_r  <= out_col_nxt;
      src_row_r  <= src_row_nxt;
      src_col_r  <= src_col_nxt;
      sub_row_r  <= sub_row_nxt;
      sub_col_r  <= sub_col_nxt;
      mismatch_r <= cfg_hit ? 1'b0 : mismatch_now;
      s1_valid_r <= acc;
      if (s1_valid_r && s1_pull_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pixel store
  assign wr_en   = acc_load && load_in_range;
  assign wr_addr = {load_row_r[PW-1:0], load_col_r[PW-1:0]};
  assign rd_addr = in_kind ? {src_row_r, src_col_r} : {anchor_row, anchor_col};

  iir_ram #(
    .WIDTH (XW),
    .DEPTH (iir_pkg::STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_pixel_in),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // read stage and output register payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_pull_r    <= in_kind;
      s1_px_r      <= in_pixel_in;
      s1_check_r   <= load_check;
      s1_clear_r   <= load_clear;
      s1_status_r  <= pull_status;
      s1_row_end_r <= !pull_err && pull_row_end;
      s1_last_r    <= pull_err || pull_last;
    end
    if (s1_valid_r && s1_pull_r) begin
      out_pixel_r   <= (s1_status_r == iir_pkg::STATUS_OK) ? rd_data : '0;
      out_status_r  <= s1_status_r;
      out_row_end_r <= s1_row_end_r;
      out_last_r    <= s1_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = out_pixel_r;
  assign out_status    = out_status_r;
  assign out_row_end   = out_row_end_r;
  assign out_last      = out_last_r;

endmodule
